>>> src/uvs_pkg.sv
package uvs_pkg;

    localparam int MAX_SEGMENTS_DEF = 1024;
    localparam int ANGLE_STAGES_DEF = 16;

    localparam logic [2:0] REG_RADIUS      = 3'd0;
    localparam logic [2:0] REG_LAT_BANDS   = 3'd1;
    localparam logic [2:0] REG_LON_STEPS   = 3'd2;
    localparam logic [2:0] REG_TEX_ENABLE  = 3'd3;
    localparam logic [2:0] REG_TEX_MAPPING = 3'd4;

    localparam logic [1:0] TEX_AZIMUTHAL   = 2'd0;
    localparam logic [1:0] TEX_CYLINDRICAL = 2'd1;
    localparam logic [1:0] TEX_NONE        = 2'd2;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;

    localparam logic [30:0] RADIUS_RESET    = 31'd65536;
    localparam logic [10:0] LAT_BANDS_RESET = 11'd16;
    localparam logic [10:0] LON_STEPS_RESET = 11'd32;

    localparam int DIV_FRAC   = 32;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = DIV_FRAC / DIV_STEPS;

    localparam logic signed [32:0] ONE30       = 33'sd1073741824;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    typedef struct packed {
        logic err;
        logic last;
    } div_side_t;

    typedef struct packed {
        logic        err;
        logic        last;
        logic [30:0] arc;
        logic [15:0] cu;
        logic [15:0] cv;
    } vtx_side_t;

    function automatic logic signed [31:0] cordic_atan(input int k);
        logic signed [31:0] a;
        case (k)
            0:  a = 32'sd536870912;
            1:  a = 32'sd316933406;
            2:  a = 32'sd167458907;
            3:  a = 32'sd85004756;
            4:  a = 32'sd42667331;
            5:  a = 32'sd21354465;
            6:  a = 32'sd10679838;
            7:  a = 32'sd5340245;
            8:  a = 32'sd2670163;
            9:  a = 32'sd1335087;
            10: a = 32'sd667544;
            11: a = 32'sd333772;
            12: a = 32'sd166886;
            13: a = 32'sd83443;
            14: a = 32'sd41722;
            15: a = 32'sd20861;
            16: a = 32'sd10430;
            17: a = 32'sd5215;
            18: a = 32'sd2608;
            19: a = 32'sd1304;
            20: a = 32'sd652;
            21: a = 32'sd326;
            22: a = 32'sd163;
            23: a = 32'sd81;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

    // one restoring step: {quotient bit, new remainder}
    function automatic logic [11:0] div_step(input logic [10:0] rem, input logic [10:0] den);
        logic [11:0] t;
        logic [11:0] d;
        t = {rem, 1'b0};
        d = {1'b0, den};
        if (t >= d) begin
            return {1'b1, 11'(t - d)};
        end
        return {1'b0, t[10:0]};
    endfunction

    function automatic logic signed [63:0] rnd64(input logic signed [63:0] v, input int s);
        logic signed [63:0] h;
        h = 64'sd1 <<< (s - 1);
        return (v + h) >>> s;
    endfunction

    function automatic logic [15:0] sat16(input logic signed [63:0] v);
        if (v > 64'sd32767) begin
            return 16'h7fff;
        end
        if (v < -64'sd32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic logic [15:0] clamp_tex(input logic signed [63:0] v);
        if (v > 64'sd32768) begin
            return 16'd32768;
        end
        if (v < 64'sd0) begin
            return 16'd0;
        end
        return v[15:0];
    endfunction

endpackage

>>> src/uv_sphere_vertex_generator_top.sv
// UV sphere vertex generator.
// Input channel (s_valid/s_ready): one grid column, a latitude band and a
// longitude step. Result channel (m_valid/m_ready): two vertices per column,
// the upper-band vertex (m_last = 0) followed by the lower-band vertex
// (m_last = 1), each with Q16.16 position, inward Q1.15 normal and Q1.15
// texture coordinate. Bad indices or counts give two all-zero vertices with
// m_range_error set.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_wr_index
// (0 radius, 1 lat_bands, 2 lon_steps, 3 tex_enable, 4 tex_mapping);
// write only while no item is in flight.
// Throughput: one vertex per cycle while m_ready does not stall; an input item
// is expanded into two vertices that share one vertex pipeline, and the next
// item is accepted as the held item's lower vertex enters the pipeline.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// registers: radius 1.0, 16 bands, 32 steps, texture off.
// A stall on m_ready freezes the whole pipeline in place; nothing is lost and
// s_ready drops, once the item hold is full, until the pipeline moves again.
module uv_sphere_vertex_generator_top #(
    parameter int MAX_SEGMENTS = uvs_pkg::MAX_SEGMENTS_DEF,
    parameter int ANGLE_STAGES = uvs_pkg::ANGLE_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_wr_index,
    input  logic [30:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [9:0]         s_band_index,
    input  logic [10:0]        s_step_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic signed [31:0] m_pos_z,
    output logic signed [15:0] m_norm_x,
    output logic signed [15:0] m_norm_y,
    output logic signed [15:0] m_norm_z,
    output logic [15:0]        m_tex_u,
    output logic [15:0]        m_tex_v,
    output logic               m_range_error,
    output logic               m_last
);
    import uvs_pkg::*;

    logic [30:0] radius_reg;
    logic [10:0] lat_bands_reg;
    logic [10:0] lon_steps_reg;
    logic        tex_enable_reg;
    logic [1:0]  tex_mapping_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg      <= RADIUS_RESET;
            lat_bands_reg   <= LAT_BANDS_RESET;
            lon_steps_reg   <= LON_STEPS_RESET;
            tex_enable_reg  <= 1'b0;
            tex_mapping_reg <= TEX_AZIMUTHAL;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_RADIUS:      radius_reg      <= cfg_wr_data;
                REG_LAT_BANDS:   lat_bands_reg   <= cfg_wr_data[10:0];
                REG_LON_STEPS:   lon_steps_reg   <= cfg_wr_data[10:0];
                REG_TEX_ENABLE:  tex_enable_reg  <= cfg_wr_data[0];
                REG_TEX_MAPPING: tex_mapping_reg <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    logic out_valid_reg;
    logic adv;

    // the whole pipeline advances when the output register can move
    assign adv = !out_valid_reg || m_ready;

    // item hold: emits the upper vertex, then the lower one
    logic        hold_v_reg;
    logic        hold_phase_reg;
    logic [9:0]  hold_band_reg;
    logic [10:0] hold_step_reg;
    logic        accept;

    assign s_ready = !hold_v_reg || (adv && hold_phase_reg);
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg     <= 1'b0;
            hold_phase_reg <= 1'b0;
        end else if (accept) begin
            hold_v_reg     <= 1'b1;
            hold_phase_reg <= 1'b0;
        end else if (adv && hold_v_reg) begin
            hold_v_reg     <= !hold_phase_reg;
            hold_phase_reg <= !hold_phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_band_reg <= s_band_index;
            hold_step_reg <= s_step_index;
        end
    end

    logic [10:0] lat_num;
    logic        counts_bad;
    div_side_t   div_side_in;

    assign lat_num = hold_phase_reg ? 11'({1'b0, hold_band_reg} + 11'd1)
                                    : {1'b0, hold_band_reg};
    assign counts_bad = (lat_bands_reg == 11'd0) || (lon_steps_reg == 11'd0)
                     || (32'(lat_bands_reg) > 32'(MAX_SEGMENTS))
                     || (32'(lon_steps_reg) > 32'(MAX_SEGMENTS));
    assign div_side_in.err  = counts_bad || ({1'b0, hold_band_reg} >= lat_bands_reg)
                           || (hold_step_reg > lon_steps_reg);
    assign div_side_in.last = hold_phase_reg;

    logic        div_valid;
    logic [32:0] q_lat;
    logic [32:0] q_lon;
    div_side_t   div_side;

    uvs_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (hold_v_reg),
        .num_a     (lat_num),
        .den_a     (lat_bands_reg),
        .num_b     (hold_step_reg),
        .den_b     (lon_steps_reg),
        .side_in   (div_side_in),
        .out_valid (div_valid),
        .quo_a     (q_lat),
        .quo_b     (q_lon),
        .side_out  (div_side)
    );

    // latitude angle, polar arc and cylindrical coordinates
    logic signed [32:0] lat_s;
    logic signed [32:0] lat_abs;
    logic [16:0]        cv_sum;
    logic [16:0]        cu_sum;
    vtx_side_t          c_side_in;

    assign lat_s   = ONE30 - $signed({1'b0, q_lat[32:1]});
    assign lat_abs = lat_s[32] ? -lat_s : lat_s;
    assign cv_sum  = q_lat[32:16] + 17'd1;
    assign cu_sum  = q_lon[32:16] + 17'd1;

    assign c_side_in.err  = div_side.err;
    assign c_side_in.last = div_side.last;
    assign c_side_in.arc  = 31'(ONE30 - lat_abs);
    assign c_side_in.cu   = cu_sum[16:1];
    assign c_side_in.cv   = cv_sum[16:1];

    logic               c_valid;
    logic signed [31:0] clat;
    logic signed [31:0] slat;
    logic signed [31:0] clon;
    logic signed [31:0] slon;
    vtx_side_t          c_side;

    uvs_cordic #(
        .ANGLE_STAGES (ANGLE_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (div_valid),
        .angle_a   (lat_s[31:0]),
        .angle_b   (q_lon[31:0]),
        .side_in   (c_side_in),
        .out_valid (c_valid),
        .cos_a     (clat),
        .sin_a     (slat),
        .cos_b     (clon),
        .sin_b     (slon),
        .side_out  (c_side)
    );

    // first products
    logic signed [31:0] radius_s;
    logic signed [31:0] cp;
    logic signed [31:0] sp;
    logic signed [31:0] arc_s;
    logic signed [63:0] p_r_next;
    logic signed [63:0] p_z_next;
    logic signed [63:0] p_nx_next;
    logic signed [63:0] p_ny_next;
    logic signed [63:0] p_u_next;
    logic signed [63:0] p_v_next;

    assign radius_s  = $signed({1'b0, radius_reg});
    assign cp        = -clon;
    assign sp        = -slon;
    assign arc_s     = $signed({1'b0, c_side.arc});
    assign p_r_next  = radius_s * clat;
    assign p_z_next  = radius_s * slat;
    assign p_nx_next = clat * cp;
    assign p_ny_next = clat * sp;
    assign p_u_next  = arc_s * slon;
    assign p_v_next  = arc_s * clon;

    logic               m1_v_reg;
    vtx_side_t          m1_side_reg;
    logic signed [63:0] p_r_reg;
    logic signed [63:0] p_z_reg;
    logic signed [63:0] p_nx_reg;
    logic signed [63:0] p_ny_reg;
    logic signed [63:0] p_u_reg;
    logic signed [63:0] p_v_reg;
    logic signed [31:0] m1_slat_reg;
    logic signed [31:0] m1_cp_reg;
    logic signed [31:0] m1_sp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
        end else if (adv) begin
            m1_v_reg <= c_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_side_reg <= c_side;
            p_r_reg     <= p_r_next;
            p_z_reg     <= p_z_next;
            p_nx_reg    <= p_nx_next;
            p_ny_reg    <= p_ny_next;
            p_u_reg     <= p_u_next;
            p_v_reg     <= p_v_next;
            m1_slat_reg <= slat;
            m1_cp_reg   <= cp;
            m1_sp_reg   <= sp;
        end
    end

    // rounding, normals and texture
    logic [1:0]         tex_mode;
    logic signed [63:0] rr_full;
    logic signed [63:0] pz_full;
    logic [15:0]        tu_next;
    logic [15:0]        tv_next;

    assign tex_mode = tex_enable_reg ? tex_mapping_reg : TEX_NONE;
    assign rr_full  = rnd64(p_r_reg, 30);
    assign pz_full  = rnd64(p_z_reg, 30);

    always_comb begin
        case (tex_mode)
            TEX_AZIMUTHAL: begin
                tu_next = clamp_tex(64'sd16384 + rnd64(p_u_reg, 46));
                tv_next = clamp_tex(64'sd16384 + rnd64(p_v_reg, 46));
            end
            TEX_CYLINDRICAL: begin
                tu_next = m1_side_reg.cu;
                tv_next = m1_side_reg.cv;
            end
            default: begin
                tu_next = 16'd0;
                tv_next = 16'd0;
            end
        endcase
    end

    logic               m2_v_reg;
    vtx_side_t          m2_side_reg;
    logic signed [31:0] rr_reg;
    logic signed [31:0] m2_pz_reg;
    logic [15:0]        m2_nx_reg;
    logic [15:0]        m2_ny_reg;
    logic [15:0]        m2_nz_reg;
    logic [15:0]        m2_tu_reg;
    logic [15:0]        m2_tv_reg;
    logic signed [31:0] m2_cp_reg;
    logic signed [31:0] m2_sp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_v_reg <= 1'b0;
        end else if (adv) begin
            m2_v_reg <= m1_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m2_side_reg <= m1_side_reg;
            rr_reg      <= rr_full[31:0];
            m2_pz_reg   <= pz_full[31:0];
            m2_nx_reg   <= sat16(-rnd64(p_nx_reg, 45));
            m2_ny_reg   <= sat16(-rnd64(p_ny_reg, 45));
            m2_nz_reg   <= sat16(-rnd64(64'(m1_slat_reg), 15));
            m2_tu_reg   <= tu_next;
            m2_tv_reg   <= tv_next;
            m2_cp_reg   <= m1_cp_reg;
            m2_sp_reg   <= m1_sp_reg;
        end
    end

    // ring radius times azimuth
    logic signed [63:0] px_p_next;
    logic signed [63:0] py_p_next;

    assign px_p_next = rr_reg * m2_cp_reg;
    assign py_p_next = rr_reg * m2_sp_reg;

    logic               m3_v_reg;
    vtx_side_t          m3_side_reg;
    logic signed [63:0] px_p_reg;
    logic signed [63:0] py_p_reg;
    logic signed [31:0] m3_pz_reg;
    logic [15:0]        m3_nx_reg;
    logic [15:0]        m3_ny_reg;
    logic [15:0]        m3_nz_reg;
    logic [15:0]        m3_tu_reg;
    logic [15:0]        m3_tv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_v_reg <= 1'b0;
        end else if (adv) begin
            m3_v_reg <= m2_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m3_side_reg <= m2_side_reg;
            px_p_reg    <= px_p_next;
            py_p_reg    <= py_p_next;
            m3_pz_reg   <= m2_pz_reg;
            m3_nx_reg   <= m2_nx_reg;
            m3_ny_reg   <= m2_ny_reg;
            m3_nz_reg   <= m2_nz_reg;
            m3_tu_reg   <= m2_tu_reg;
            m3_tv_reg   <= m2_tv_reg;
        end
    end

    // output register; a rejected item drops every position, normal and texture field to zero
    logic signed [63:0] px_full;
    logic signed [63:0] py_full;
    logic               zero;

    assign px_full = rnd64(px_p_reg, 30);
    assign py_full = rnd64(py_p_reg, 30);
    assign zero    = m3_side_reg.err;

    logic signed [31:0] out_px_reg;
    logic signed [31:0] out_py_reg;
    logic signed [31:0] out_pz_reg;
    logic [15:0]        out_nx_reg;
    logic [15:0]        out_ny_reg;
    logic [15:0]        out_nz_reg;
    logic [15:0]        out_tu_reg;
    logic [15:0]        out_tv_reg;
    logic               out_err_reg;
    logic               out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= m3_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_px_reg   <= zero ? 32'sd0 : px_full[31:0];
            out_py_reg   <= zero ? 32'sd0 : py_full[31:0];
            out_pz_reg   <= zero ? 32'sd0 : m3_pz_reg;
            out_nx_reg   <= zero ? 16'd0 : m3_nx_reg;
            out_ny_reg   <= zero ? 16'd0 : m3_ny_reg;
            out_nz_reg   <= zero ? 16'd0 : m3_nz_reg;
            out_tu_reg   <= zero ? 16'd0 : m3_tu_reg;
            out_tv_reg   <= zero ? 16'd0 : m3_tv_reg;
            out_err_reg  <= zero;
            out_last_reg <= m3_side_reg.last;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pos_x       = out_px_reg;
    assign m_pos_y       = out_py_reg;
    assign m_pos_z       = out_pz_reg;
    assign m_norm_x      = $signed(out_nx_reg);
    assign m_norm_y      = $signed(out_ny_reg);
    assign m_norm_z      = $signed(out_nz_reg);
    assign m_tex_u       = out_tu_reg;
    assign m_tex_v       = out_tv_reg;
    assign m_range_error = out_err_reg;
    assign m_last        = out_last_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_range_error |-> m_pos_x == 0 && m_pos_y == 0 && m_pos_z == 0
            && m_norm_x == 0 && m_norm_z == 0 && m_tex_u == 0 && m_tex_v == 0)
        else $error("rejected item carries nonzero fields");

    a_one_item_held: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted before the first was expanded");

    a_phase_held: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_phase_reg |-> hold_v_reg)
        else $error("lower vertex phase without a held item");

    a_tex_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_tex_u <= 16'd32768 && m_tex_v <= 16'd32768)
        else $error("texture coordinate above 1.0");

endmodule

>>> src/uvs_divider.sv
module uvs_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [10:0]        num_a,
    input  logic [10:0]        den_a,
    input  logic [10:0]        num_b,
    input  logic [10:0]        den_b,
    input  uvs_pkg::div_side_t side_in,
    output logic               out_valid,
    output logic [32:0]        quo_a,
    output logic [32:0]        quo_b,
    output uvs_pkg::div_side_t side_out
);
    import uvs_pkg::*;

    logic        vld_reg  [0:DIV_STAGES];
    div_side_t   side_reg [0:DIV_STAGES];
    logic [10:0] rem_a_reg [0:DIV_STAGES];
    logic [10:0] rem_b_reg [0:DIV_STAGES];
    logic [32:0] quo_a_reg [0:DIV_STAGES];
    logic [32:0] quo_b_reg [0:DIV_STAGES];

    logic int_a;
    logic int_b;

    // integer step: numerators never exceed the divisor on accepted work
    assign int_a = (num_a >= den_a);
    assign int_b = (num_b >= den_b);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0]  <= side_in;
            rem_a_reg[0] <= int_a ? 11'(num_a - den_a) : num_a;
            rem_b_reg[0] <= int_b ? 11'(num_b - den_b) : num_b;
            quo_a_reg[0] <= {32'd0, int_a};
            quo_b_reg[0] <= {32'd0, int_b};
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [10:0] ra_next;
        logic [10:0] rb_next;
        logic [32:0] qa_next;
        logic [32:0] qb_next;
        logic [11:0] sa;
        logic [11:0] sb;

        always_comb begin
            ra_next = rem_a_reg[k];
            rb_next = rem_b_reg[k];
            qa_next = quo_a_reg[k];
            qb_next = quo_b_reg[k];
            sa = 12'd0;
            sb = 12'd0;
            for (int i = 0; i < DIV_STEPS; i++) begin
                sa = div_step(ra_next, den_a);
                sb = div_step(rb_next, den_b);
                ra_next = sa[10:0];
                rb_next = sb[10:0];
                qa_next = {qa_next[31:0], sa[11]};
                qb_next = {qb_next[31:0], sb[11]};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1]  <= side_reg[k];
                rem_a_reg[k+1] <= ra_next;
                rem_b_reg[k+1] <= rb_next;
                quo_a_reg[k+1] <= qa_next;
                quo_b_reg[k+1] <= qb_next;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES];
    assign quo_a     = quo_a_reg[DIV_STAGES];
    assign quo_b     = quo_b_reg[DIV_STAGES];
    assign side_out  = side_reg[DIV_STAGES];

endmodule

>>> src/uvs_cordic.sv
module uvs_cordic #(
    parameter int ANGLE_STAGES = uvs_pkg::ANGLE_STAGES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [31:0]        angle_a,
    input  logic [31:0]        angle_b,
    input  uvs_pkg::vtx_side_t side_in,
    output logic               out_valid,
    output logic signed [31:0] cos_a,
    output logic signed [31:0] sin_a,
    output logic signed [31:0] cos_b,
    output logic signed [31:0] sin_b,
    output uvs_pkg::vtx_side_t side_out
);
    import uvs_pkg::*;

    localparam int N = ANGLE_STAGES;

    logic               vld_reg  [0:N];
    vtx_side_t          side_reg [0:N];
    logic signed [32:0] x_reg [0:N][0:1];
    logic signed [32:0] y_reg [0:N][0:1];
    logic signed [31:0] z_reg [0:N][0:1];
    logic [1:0]         q_reg [0:N][0:1];

    logic               out_valid_reg;
    vtx_side_t          out_side_reg;
    logic signed [31:0] cos_reg [0:1];
    logic signed [31:0] sin_reg [0:1];

    logic [31:0] angle [0:1];
    assign angle[0] = angle_a;
    assign angle[1] = angle_b;

    function automatic logic signed [31:0] clamp30(input logic signed [32:0] v);
        if (v > ONE30) begin
            return ONE30[31:0];
        end
        if (v < -ONE30) begin
            return 32'(-ONE30);
        end
        return v[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_load
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[0][l] <= CORDIC_GAIN;
                y_reg[0][l] <= 33'sd0;
                z_reg[0][l] <= $signed({2'b00, angle[l][29:0]});
                q_reg[0][l] <= angle[l][31:30];
            end
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_reg[k];
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            always_ff @(posedge aclk) begin
                if (en) begin
                    q_reg[k+1][l] <= q_reg[k][l];
                    if (z_reg[k][l] >= 0) begin
                        x_reg[k+1][l] <= x_reg[k][l] - (y_reg[k][l] >>> k);
                        y_reg[k+1][l] <= y_reg[k][l] + (x_reg[k][l] >>> k);
                        z_reg[k+1][l] <= z_reg[k][l] - cordic_atan(k);
                    end else begin
                        x_reg[k+1][l] <= x_reg[k][l] + (y_reg[k][l] >>> k);
                        y_reg[k+1][l] <= y_reg[k][l] - (x_reg[k][l] >>> k);
                        z_reg[k+1][l] <= z_reg[k][l] + cordic_atan(k);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= vld_reg[N];
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_out
        logic signed [31:0] xc;
        logic signed [31:0] yc;
        assign xc = clamp30(x_reg[N][l]);
        assign yc = clamp30(y_reg[N][l]);

        always_ff @(posedge aclk) begin
            if (en) begin
                case (q_reg[N][l])
                    QUAD_I: begin
                        cos_reg[l] <= xc;
                        sin_reg[l] <= yc;
                    end
                    QUAD_II: begin
                        cos_reg[l] <= -yc;
                        sin_reg[l] <= xc;
                    end
                    QUAD_III: begin
                        cos_reg[l] <= -xc;
                        sin_reg[l] <= -yc;
                    end
                    default: begin
                        cos_reg[l] <= yc;
                        sin_reg[l] <= -xc;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_side_reg <= side_reg[N];
        end
    end

    assign out_valid = out_valid_reg;
    assign side_out  = out_side_reg;
    assign cos_a     = cos_reg[0];
    assign sin_a     = sin_reg[0];
    assign cos_b     = cos_reg[1];
    assign sin_b     = sin_reg[1];

endmodule

>>> dv/tb.sv
module tb;
    import uvs_pkg::*;

    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 80;
    localparam logic signed [63:0] ONE = 64'sd1073741824;
    localparam logic signed [63:0] GAIN = 64'sd652032874;

    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [15:0] nz;
        logic [15:0] tu;
        logic [15:0] tv;
        logic        err;
        logic        last;
    } vertex_t;

    typedef struct {
        logic [9:0]  band;
        logic [10:0] step;
        logic        has_exp;
        vertex_t     upper;
        vertex_t     lower;
    } column_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [2:0]         cfg_wr_index;
    logic [30:0]        cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [9:0]         s_band_index;
    logic [10:0]        s_step_index;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic signed [31:0] m_pos_z;
    logic signed [15:0] m_norm_x;
    logic signed [15:0] m_norm_y;
    logic signed [15:0] m_norm_z;
    logic [15:0]        m_tex_u;
    logic [15:0]        m_tex_v;
    logic               m_range_error;
    logic               m_last;

    uv_sphere_vertex_generator_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_band_index (s_band_index),
        .s_step_index (s_step_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pos_x      (m_pos_x),
        .m_pos_y      (m_pos_y),
        .m_pos_z      (m_pos_z),
        .m_norm_x     (m_norm_x),
        .m_norm_y     (m_norm_y),
        .m_norm_z     (m_norm_z),
        .m_tex_u      (m_tex_u),
        .m_tex_v      (m_tex_v),
        .m_range_error(m_range_error),
        .m_last       (m_last)
    );

    logic [30:0] radius_q;
    logic [10:0] bands_q;
    logic [10:0] steps_q;
    logic        tex_en_q;
    logic [1:0]  tex_map_q;

    vertex_t expected_vertices[$];
    int      mismatch_count;
    longint  cycle_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_off_cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] round_shr(logic signed [63:0] v, int s);
        return shr_floor(v + (64'sd1 <<< (s - 1)), s);
    endfunction

    function automatic logic signed [63:0] clip(logic signed [63:0] v,
                                               logic signed [63:0] lo,
                                               logic signed [63:0] hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic signed [63:0] turn_atan(int k);
        logic signed [63:0] t [0:15];
        t = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
              10679838, 5340245, 2670163, 1335087, 667544, 333772,
              166886, 83443, 41722, 20861};
        return t[k];
    endfunction

    task automatic turn_sincos(input logic [31:0] a,
                               output logic signed [63:0] c,
                               output logic signed [63:0] s);
        logic signed [63:0] x, y, z, dx, dy;
        x = GAIN;
        y = 0;
        z = {34'd0, a[29:0]};
        for (int k = 0; k < ANGLE_STAGES_DEF; k++) begin
            dx = shr_floor(y, k);
            dy = shr_floor(x, k);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - turn_atan(k);
            end else begin
                x = x + dx; y = y - dy; z = z + turn_atan(k);
            end
        end
        x = clip(x, -ONE, ONE);
        y = clip(y, -ONE, ONE);
        case (a[31:30])
            QUAD_I:   begin c = x;  s = y;  end
            QUAD_II:  begin c = -y; s = x;  end
            QUAD_III: begin c = -x; s = -y; end
            default:  begin c = y;  s = -x; end
        endcase
    endtask

    function automatic logic [15:0] cyl_coord(logic [63:0] n, logic [63:0] d);
        return 16'((n * 65536 + d) / (2 * d));
    endfunction

    task automatic build_vertex(input logic signed [63:0] lat,
                                input logic signed [63:0] cl,
                                input logic signed [63:0] sl,
                                input int mode,
                                input logic [15:0] cu,
                                input logic [15:0] cv,
                                input logic is_last,
                                output vertex_t v);
        logic signed [63:0] clat, slat, rr, rad, cp, sp, arc;
        rad = {33'd0, radius_q};
        cp = -cl;
        sp = -sl;
        turn_sincos(lat[31:0], clat, slat);
        rr = round_shr(rad * clat, 30);
        v.pz = 32'(round_shr(rad * slat, 30));
        v.px = 32'(round_shr(rr * cp, 30));
        v.py = 32'(round_shr(rr * sp, 30));
        v.nx = 16'(clip(-round_shr(clat * cp, 45), -32768, 32767));
        v.ny = 16'(clip(-round_shr(clat * sp, 45), -32768, 32767));
        v.nz = 16'(clip(-round_shr(slat, 15), -32768, 32767));
        v.tu = '0;
        v.tv = '0;
        if (mode == 0) begin
            arc = ONE - (lat < 0 ? -lat : lat);
            v.tu = 16'(clip(16384 + round_shr(arc * sl, 46), 0, 32768));
            v.tv = 16'(clip(16384 + round_shr(arc * cl, 46), 0, 32768));
        end else if (mode == 1) begin
            v.tu = cu;
            v.tv = cv;
        end
        v.err = 1'b0;
        v.last = is_last;
    endtask

    task automatic predict_column(input logic [9:0] band, input logic [10:0] step,
                                  output vertex_t up, output vertex_t lo);
        logic [63:0]        b, j;
        logic signed [63:0] lat_up, lat_lo, cl, sl;
        logic [63:0]        lon;
        int                 mode;
        logic [15:0]        cu, cv0, cv1;
        b = band;
        j = step;
        if (bands_q == 0 || bands_q > MAX_SEGMENTS_DEF || steps_q == 0 ||
            steps_q > MAX_SEGMENTS_DEF || b >= bands_q || j > steps_q) begin
            up = '0;
            lo = '0;
            up.err = 1'b1;
            lo.err = 1'b1;
            lo.last = 1'b1;
            return;
        end
        lat_up = ONE - $signed((b << 31) / bands_q);
        lat_lo = ONE - $signed(((b + 1) << 31) / bands_q);
        if (lat_lo < -ONE) lat_lo = -ONE;
        lon = ((j << 32) / steps_q) & 64'hFFFF_FFFF;
        turn_sincos(lon[31:0], cl, sl);
        mode = (tex_en_q && tex_map_q <= TEX_CYLINDRICAL) ? int'(tex_map_q) : 2;
        cu = '0; cv0 = '0; cv1 = '0;
        if (mode == 1) begin
            cu = cyl_coord(j, steps_q);
            cv0 = cyl_coord(b, bands_q);
            cv1 = cyl_coord(b + 1, bands_q);
        end
        build_vertex(lat_up, cl, sl, mode, cu, cv0, 1'b0, up);
        build_vertex(lat_lo, cl, sl, mode, cu, cv1, 1'b1, lo);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want,
                 cycle_count);
        mismatch_count++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_RADIUS:      radius_q = val;
            REG_LAT_BANDS:   bands_q = val[10:0];
            REG_LON_STEPS:   steps_q = val[10:0];
            REG_TEX_ENABLE:  tex_en_q = val[0];
            REG_TEX_MAPPING: tex_map_q = val[1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [30:0] rad, input logic [10:0] nb,
                                 input logic [10:0] ns, input logic en,
                                 input logic [1:0] map);
        write_reg(REG_RADIUS, rad);
        write_reg(REG_LAT_BANDS, {20'd0, nb});
        write_reg(REG_LON_STEPS, {20'd0, ns});
        write_reg(REG_TEX_ENABLE, {30'd0, en});
        write_reg(REG_TEX_MAPPING, {29'd0, map});
    endtask

    task automatic queue_vertex(input vertex_t v);
        expected_vertices = {expected_vertices, v};
    endtask

    // entered and left at a falling edge; valid stays up between back-to-back items
    task automatic send_column(input logic [9:0] band, input logic [10:0] step);
        vertex_t up, lo;
        predict_column(band, step, up, lo);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_band_index <= band;
        s_step_index <= step;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        queue_vertex(up);
        queue_vertex(lo);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_vertices.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic send_random(input int n, input int in_range_pct);
        logic [9:0]  b;
        logic [10:0] j;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < in_range_pct && bands_q != 0 && steps_q != 0 &&
                bands_q <= MAX_SEGMENTS_DEF && steps_q <= MAX_SEGMENTS_DEF) begin
                b = 10'($urandom_range(bands_q - 1));
                j = 11'($urandom_range(steps_q));
            end else begin
                b = 10'($urandom);
                j = 11'($urandom);
            end
            send_column(b, j);
        end
    endtask

    always @(posedge aclk) begin
        vertex_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_pos_x, m_pos_y, m_pos_z, m_norm_x, m_norm_y, m_norm_z,
                    m_tex_u, m_tex_v, m_range_error, m_last};
            if (expected_vertices.size() == 0) begin
                report_mismatch("unexpected vertex", 0, 0);
            end else begin
                want = expected_vertices.pop_front();
                if (got.px != want.px) report_mismatch("pos_x", got.px, want.px);
                if (got.py != want.py) report_mismatch("pos_y", got.py, want.py);
                if (got.pz != want.pz) report_mismatch("pos_z", got.pz, want.pz);
                if (got.nx != want.nx) report_mismatch("norm_x", got.nx, want.nx);
                if (got.ny != want.ny) report_mismatch("norm_y", got.ny, want.ny);
                if (got.nz != want.nz) report_mismatch("norm_z", got.nz, want.nz);
                if (got.tu != want.tu) report_mismatch("tex_u", got.tu, want.tu);
                if (got.tv != want.tv) report_mismatch("tex_v", got.tv, want.tv);
                if (got.err != want.err) report_mismatch("range_error", got.err, want.err);
                if (got.last != want.last) report_mismatch("last", got.last, want.last);
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        column_row_t rows [0:5];
        vertex_t     err_up, err_lo;
        err_up = '0;
        err_up.err = 1'b1;
        err_lo = err_up;
        err_lo.last = 1'b1;
        mismatch_count = 0;
        cycle_count = 0;
        send_idle_pct = 7;
        recv_idle_pct = 70;
        hold_off_cycles = 0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = REG_RADIUS;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_band_index = '0;
        s_step_index = '0;
        m_ready = 1'b0;
        radius_q = RADIUS_RESET;
        bands_q = LAT_BANDS_RESET;
        steps_q = LON_STEPS_RESET;
        tex_en_q = 1'b0;
        tex_map_q = TEX_AZIMUTHAL;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        rows = '{'{10'd0, 11'd0, 1'b0, '0, '0},
                 '{10'd15, 11'd32, 1'b0, '0, '0},
                 '{10'd7, 11'd8, 1'b0, '0, '0},
                 '{10'd16, 11'd0, 1'b1, err_up, err_lo},
                 '{10'd0, 11'd33, 1'b1, err_up, err_lo},
                 '{10'd1023, 11'd2047, 1'b1, err_up, err_lo}};
        foreach (rows[i]) begin
            send_column(rows[i].band, rows[i].step);
            if (rows[i].has_exp) begin
                expected_vertices[$ - 1] = rows[i].upper;
                expected_vertices[$] = rows[i].lower;
            end
        end
        wait_idle();

        apply_setting(31'h7FFF_FFFF, 11'd1024, 11'd1024, 1'b1, TEX_AZIMUTHAL);
        send_column(10'd0, 11'd0);
        send_column(10'd1023, 11'd1024);
        send_column(10'd511, 11'd256);
        wait_idle();
        apply_setting(31'd1, 11'd1, 11'd1, 1'b1, TEX_CYLINDRICAL);
        send_column(10'd0, 11'd0);
        send_column(10'd0, 11'd1);
        send_column(10'd1, 11'd0);
        wait_idle();
        apply_setting(31'd65536, 11'd0, 11'd1025, 1'b1, TEX_NONE);
        send_column(10'd0, 11'd0);
        send_column(10'd3, 11'd3);
        wait_idle();
        write_reg(REG_TEX_MAPPING, 31'd3);
        write_reg(REG_LAT_BANDS, 31'd2047);
        write_reg(REG_LON_STEPS, 31'd4);
        send_column(10'd0, 11'd0);
        wait_idle();

        apply_setting(31'd200000, 11'd12, 11'd24, 1'b1, TEX_AZIMUTHAL);
        send_random(250, 90);
        hold_off_cycles = 300;
        send_random(30, 90);
        wait_idle();

        send_idle_pct = 70;
        recv_idle_pct = 7;
        apply_setting(31'($urandom), 11'($urandom_range(1, 1024)),
                      11'($urandom_range(1, 1024)), 1'b1, TEX_CYLINDRICAL);
        send_random(300, 90);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_setting(31'($urandom), 11'($urandom_range(1, 64)),
                      11'($urandom_range(1, 64)), 1'($urandom), 2'($urandom));
        send_random(400, 90);
        wait_idle();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
